/* hdl/afr_pkg.sv */
// Shared types and constants for the API frame receiver.
// No dependencies; imported by every module of the block.
package afr_pkg;

  localparam int ByteW = 8;
  localparam int WordW = 16;

  // Event codes carried by event_code
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_START   = 3'd1;
  localparam logic [2:0] EV_PAYLOAD = 3'd2;
  localparam logic [2:0] EV_GOOD    = 3'd3;
  localparam logic [2:0] EV_BADSUM  = 3'd4;
  localparam logic [2:0] EV_REJECT  = 3'd5;

  // Command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_START_BYTE    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd2;

  localparam logic [ByteW-1:0] START_BYTE_RST    = 8'd126;
  localparam logic [WordW-1:0] TIMEOUT_TICKS_RST = 16'd100;
  localparam logic [WordW-1:0] MAX_PAYLOAD_RST   = 16'd256;
  localparam logic [ByteW-1:0] CHECK_BASE        = 8'hFF;
  localparam logic [WordW-1:0] IDLE_MAX          = 16'hFFFF;

  typedef enum logic [1:0] {
    HDR_LEN_HI,
    HDR_LEN_LO,
    HDR_BODY
  } hdr_stage_t;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [WordW-1:0] timeout_ticks;
    logic [WordW-1:0] max_payload;
  } afr_cfg_t;

  typedef struct packed {
    logic             receiving;
    hdr_stage_t       header_stage;
    logic [WordW-1:0] byte_position;
    logic [WordW-1:0] declared_length;
    logic [ByteW-1:0] running_sum;
    logic [WordW-1:0] idle_count;
  } afr_state_t;

  typedef struct packed {
    logic [2:0]       event_code;
    logic [ByteW-1:0] payload_byte;
    logic [WordW-1:0] payload_index;
    logic [WordW-1:0] frame_length;
  } afr_result_t;

endpackage

/* hdl/afr_config.sv */
// Configuration register file of the API frame receiver.
// Depends on afr_pkg for register indexes and reset values.
module afr_config (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [1:0]           wr_index,
  input  logic [15:0]          wr_data,
  output afr_pkg::afr_cfg_t    cfg
);
  import afr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= START_BYTE_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg.max_payload   <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START_BYTE:    cfg.start_byte    <= wr_data[ByteW-1:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= wr_data;
        REG_MAX_PAYLOAD:   cfg.max_payload   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/afr_step.sv */
// Per-item deframing logic: next frame state and result for one item.
// Purely combinational; depends on afr_pkg for types and codes.
module afr_step (
  input  afr_pkg::afr_cfg_t    cfg,
  input  afr_pkg::afr_state_t  state,
  input  logic                 command,
  input  logic [7:0]           rx_byte,
  output afr_pkg::afr_state_t  state_next,
  output afr_pkg::afr_result_t result
);
  import afr_pkg::*;

  logic             timed_out;
  logic             active;
  logic [WordW-1:0] len_full;
  logic             len_reject;
  logic             in_payload;
  logic [ByteW-1:0] expect_sum;

  assign timed_out  = state.idle_count > cfg.timeout_ticks;
  assign active     = state.receiving && !timed_out;
  assign len_full   = {state.declared_length[WordW-1:ByteW], rx_byte};
  assign len_reject = len_full >= cfg.max_payload;
  assign in_payload = state.byte_position < state.declared_length;
  assign expect_sum = CHECK_BASE - state.running_sum;

  always_comb begin
    state_next           = state;
    result.event_code    = EV_NONE;
    result.payload_byte  = '0;
    result.payload_index = '0;

    if (command == CMD_TICK) begin
      // saturate the idle counter
      if (state.idle_count != IDLE_MAX) begin
        state_next.idle_count = state.idle_count + 16'd1;
      end
    end else begin
      state_next.idle_count = '0;
      state_next.receiving  = active;
      if (!active) begin
        if (rx_byte == cfg.start_byte) begin
          state_next.receiving       = 1'b1;
          state_next.header_stage    = HDR_LEN_HI;
          state_next.byte_position   = '0;
          state_next.declared_length = '0;
          state_next.running_sum     = '0;
          result.event_code          = EV_START;
        end
      end else begin
        unique case (state.header_stage)
          HDR_LEN_HI: begin
            state_next.declared_length = {rx_byte, 8'd0};
            state_next.header_stage    = HDR_LEN_LO;
          end
          HDR_LEN_LO: begin
            state_next.declared_length = len_full;
            if (len_reject) begin
              state_next.receiving = 1'b0;
              result.event_code    = EV_REJECT;
            end else begin
              state_next.header_stage = HDR_BODY;
            end
          end
          default: begin
            if (in_payload) begin
              result.payload_byte      = rx_byte;
              result.payload_index     = state.byte_position;
              state_next.running_sum   = state.running_sum + rx_byte;
              state_next.byte_position = state.byte_position + 16'd1;
              result.event_code        = EV_PAYLOAD;
            end else begin
              result.event_code    = (expect_sum == rx_byte) ? EV_GOOD : EV_BADSUM;
              state_next.receiving = 1'b0;
            end
          end
        endcase
      end
    end

    result.frame_length = state_next.declared_length;
  end

endmodule

/* hdl/api_frame_receiver_core.sv */
// API frame receiver: input register, deframing step and result register.
// Uses afr_pkg, afr_config and afr_step.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transfer: a received
//   byte (command 0) or a millisecond tick (command 1). Every item gives exactly
//   one result on the output channel (out_valid/out_stall): an event code, the
//   payload byte and its index for payload events, and the declared length.
//   An accepted item goes into the input register; when it advances, its result
//   is written to the result register and out_valid is set. Throughput is one
//   item per cycle while the receiver does not stall; the frame state is updated
//   by the combinational afr_step between the input register and the result register.
//   When the receiver raises out_stall the result register holds; the item in
//   the input register waits, and in_stall rises only once both are full, so
//   at most two items are held inside.
//   Reset clears the frame state (hunting for the start byte, idle count 0) and
//   loads the register defaults: start byte 126, timeout 100 ticks, payload
//   limit 256. Registers are written through wr_en/wr_index/wr_data; the user
//   must do so only while the block holds no items, which it does not enforce.
module api_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_code,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [15:0] frame_length
);
  import afr_pkg::*;

  afr_cfg_t    cfg;
  afr_state_t  state;
  afr_state_t  state_next;
  afr_result_t result;

  logic             hold_valid;
  logic             hold_command;
  logic [ByteW-1:0] hold_byte;
  logic             advance;

  afr_config u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  afr_step u_step (
    .cfg        (cfg),
    .state      (state),
    .command    (hold_command),
    .rx_byte    (hold_byte),
    .state_next (state_next),
    .result     (result)
  );

  // advance the held item when the result register is free or being taken
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      hold_command <= command;
      hold_byte    <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '{receiving: 1'b0, header_stage: HDR_LEN_HI, default: '0};
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      event_code    <= result.event_code;
      payload_byte  <= result.payload_byte;
      payload_index <= result.payload_index;
      frame_length  <= result.frame_length;
    end
  end

endmodule
